// File: hw/rtl/kta_pkg.sv
// Shared types and constants for the keyed table with aging.
package kta_pkg;

   // Default geometry
   localparam int DEF_CAPACITY = 16;
   localparam int DEF_KEY_BITS = 64;

   // Fixed field widths
   localparam int DATA_W  = 64;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   localparam logic [COUNT_W-1:0] MAX_RESULTS = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_SAT   = 5'd31;
   localparam logic [DATA_W-1:0]  SIGN_BIT    = 64'h8000_0000_0000_0000;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Operation codes
   typedef enum logic [1:0] {
      OP_UPSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_PRUNE    = 2'd2,
      OP_SNAPSHOT = 2'd3
   } op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   // Sequencer controls toward the datapath
   typedef struct packed {
      logic busy;    // a transaction is in progress
      logic rd_en;   // read the entry RAM at the scan address
      logic chk;     // read data for chk_idx is present this cycle
      logic finish;  // final cycle: commit and report
   } seq_ctl_type;

endpackage

// File: hw/rtl/kta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kta_ram #(
   parameter int WIDTH = kta_pkg::DEF_KEY_BITS + 2 * kta_pkg::DATA_W,
   parameter int DEPTH = kta_pkg::DEF_CAPACITY
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kta_seq.sv
// Scan sequencer: walks every slot once per transaction unless stopped, one RAM read a cycle.
module kta_seq #(
   parameter int CAPACITY = kta_pkg::DEF_CAPACITY
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         stop,
   output kta_pkg::seq_ctl_type         ctl,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] chk_idx
);

   localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   kta_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               chk_ff, chk_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kta_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = kta_pkg::ST_SCAN;
            end
         end
         kta_pkg::ST_SCAN: begin
            if (stop) begin
               state_in = kta_pkg::ST_IDLE;
            end else if (addr_ff == LAST_IDX) begin
               state_in = kta_pkg::ST_DRAIN;
            end
         end
         kta_pkg::ST_DRAIN: begin
            if (stop) begin
               state_in = kta_pkg::ST_IDLE;
            end else begin
               state_in = kta_pkg::ST_FINISH;
            end
         end
         kta_pkg::ST_FINISH: begin
            state_in = kta_pkg::ST_IDLE;
         end
         default: begin
            state_in = kta_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctl.busy   = 1'b1;
      ctl.rd_en  = 1'b0;
      ctl.finish = 1'b0;
      case (state_ff)
         kta_pkg::ST_IDLE: begin
            ctl.busy = 1'b0;
         end
         kta_pkg::ST_SCAN: begin
            ctl.rd_en = 1'b1;
         end
         kta_pkg::ST_DRAIN: begin
            ctl.rd_en = 1'b0;
         end
         kta_pkg::ST_FINISH: begin
            ctl.finish = 1'b1;
         end
         default: begin
            ctl.busy = 1'b0;
         end
      endcase
      ctl.chk = chk_ff;
   end

   // Scan address and the index whose read data is due next cycle
   always_comb begin
      addr_in    = addr_ff;
      chk_in     = (state_ff == kta_pkg::ST_SCAN) && !stop;
      chk_idx_in = addr_ff;
      if (accept) begin
         addr_in = '0;
      end else if (state_ff == kta_pkg::ST_SCAN) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kta_pkg::ST_IDLE;
         addr_ff  <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
   end

   assign rd_addr = addr_ff;
   assign chk_idx = chk_idx_ff;

endmodule

// File: hw/rtl/keyed_table_with_aging.sv
// Top level: keyed table with aging, entries in RAM, valid marks in flops.
//
//   channel   handshake                  direction  contents
//   request   start / busy               in         req_operation, req_key, req_payload,
//                                                   req_timestamp, req_ttl, req_max_out
//   response  rsp_strobe (one cycle)     out        rsp_status, rsp_slot, rsp_count,
//                                                   rsp_entry_*, rsp_last
//
// Every transaction but a snapshot that ends early reads each slot of the entry RAM once,
// one slot per cycle; busy stays high through the scan, the RAM read and the commit.
// A snapshot emits entries as the scan finds them and stops at its limit or its last valid entry.
// Reset clears all valid marks at once; the table is empty and usable right after.
// Responses cannot be stalled: each is shown for exactly one cycle on rsp_strobe.
module keyed_table_with_aging #(
   parameter int CAPACITY = kta_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = kta_pkg::DEF_KEY_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [kta_pkg::DATA_W-1:0]           req_key,
   input  logic [kta_pkg::DATA_W-1:0]           req_payload,
   input  logic signed [kta_pkg::DATA_W-1:0]    req_timestamp,
   input  logic signed [kta_pkg::DATA_W-1:0]    req_ttl,
   input  logic [kta_pkg::COUNT_W-1:0]          req_max_out,
   output logic                                 rsp_strobe,
   output logic                                 rsp_status,
   output logic [kta_pkg::SLOT_W-1:0]           rsp_slot,
   output logic [kta_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_entry_valid,
   output logic [kta_pkg::DATA_W-1:0]           rsp_entry_key,
   output logic [kta_pkg::DATA_W-1:0]           rsp_entry_payload,
   output logic signed [kta_pkg::DATA_W-1:0]    rsp_entry_time,
   output logic                                 rsp_last
);

   localparam int IDX_W = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam int DW    = kta_pkg::DATA_W;
   localparam int CW    = kta_pkg::COUNT_W;
   localparam int SW    = kta_pkg::SLOT_W;
   localparam int RAM_W = KEY_BITS + 2 * DW;

   kta_pkg::seq_ctl_type ctl;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     chk_idx;
   logic                 accept;
   logic                 stop;

   // Latched request
   kta_pkg::op_type      op_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [DW-1:0]        payload_ff;
   logic [DW-1:0]        time_ff;
   logic [DW-1:0]        limit_ff;
   logic                 prune_en_ff;
   logic [CW-1:0]        lim_ff;

   // Scan results
   logic                 match_found_ff, match_found_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CAPACITY-1:0]  valid_ff, valid_in;

   // Response registers
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [SW-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;
   logic                 rsp_ev_ff, rsp_ev_in;
   logic [DW-1:0]        rsp_key_ff, rsp_key_in;
   logic [DW-1:0]        rsp_pay_ff, rsp_pay_in;
   logic [DW-1:0]        rsp_time_ff, rsp_time_in;
   logic                 rsp_last_ff, rsp_last_in;

   // RAM access
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [RAM_W-1:0]     rd_data;
   logic [KEY_BITS-1:0]  rd_key;
   logic [DW-1:0]        rd_pay;
   logic [DW-1:0]        rd_time;

   // Request-side arithmetic
   logic [DW-1:0]        bnow;
   logic [DW:0]          diff;
   logic [CW-1:0]        lim_in;

   // Check-stage helpers
   logic                 chk_valid;
   logic [CAPACITY-1:0]  after_mask;
   logic                 more_after;
   logic [KEY_BITS+DW-1:0] key_ext;
   logic [IDX_W+SW-1:0]  slot_ext;
   logic [IDX_W-1:0]     done_idx;
   logic                 done_ok;

   assign accept = start && !ctl.busy;
   assign busy   = ctl.busy;

   kta_seq #(
      .CAPACITY(CAPACITY)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .stop    (stop),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .chk_idx (chk_idx)
   );

   kta_ram #(
      .WIDTH(RAM_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({key_ff, payload_ff, time_ff}),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_time = rd_data[DW-1:0];
   assign rd_pay  = rd_data[2*DW-1:DW];
   assign rd_key  = rd_data[RAM_W-1:2*DW];

   // Prune limit in 65 bits on biased times; a borrow means nothing can be older
   assign bnow   = $unsigned(req_timestamp) ^ kta_pkg::SIGN_BIT;
   assign diff   = {1'b0, bnow} - {1'b0, $unsigned(req_ttl)};
   assign lim_in = (req_max_out > kta_pkg::MAX_RESULTS) ? kta_pkg::MAX_RESULTS : req_max_out;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= kta_pkg::op_type'(req_operation);
         key_ff      <= req_key[KEY_BITS-1:0];
         payload_ff  <= req_payload;
         time_ff     <= $unsigned(req_timestamp);
         limit_ff    <= diff[DW-1:0];
         prune_en_ff <= !req_ttl[DW-1] && !diff[DW];
         lim_ff      <= lim_in;
      end
   end

   // Slots after the one being checked, for the last-entry flag of a snapshot
   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         after_mask[j] = IDX_W'(j) > chk_idx;
      end
   end

   assign more_after = |(valid_ff & after_mask);
   assign chk_valid  = valid_ff[chk_idx];
   assign key_ext    = {{DW{1'b0}}, rd_key};

   // Outcome of upsert and remove at commit time
   always_comb begin
      done_ok  = 1'b0;
      done_idx = match_idx_ff;
      if (key_ff != '0) begin
         if (match_found_ff) begin
            done_ok = 1'b1;
         end else if (op_ff == kta_pkg::OP_UPSERT && free_found_ff) begin
            done_ok  = 1'b1;
            done_idx = free_idx_ff;
         end
      end
   end

   assign slot_ext = {{SW{1'b0}}, done_idx};
   assign wr_en    = ctl.finish && op_ff == kta_pkg::OP_UPSERT && done_ok;
   assign wr_addr  = done_idx;

   // Check stage and commit
   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      valid_in       = valid_ff;
      stop           = 1'b0;

      rsp_strobe_in  = 1'b0;
      rsp_status_in  = kta_pkg::STATUS_OK;
      rsp_slot_in    = '0;
      rsp_count_in   = '0;
      rsp_ev_in      = 1'b0;
      rsp_key_in     = '0;
      rsp_pay_in     = '0;
      rsp_time_in    = '0;
      rsp_last_in    = 1'b0;

      if (accept) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         count_in       = '0;
      end

      if (ctl.chk) begin
         case (op_ff)
            kta_pkg::OP_UPSERT, kta_pkg::OP_REMOVE: begin
               if (chk_valid && rd_key == key_ff && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_idx_in   = chk_idx;
               end
               if (!chk_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx;
               end
            end
            kta_pkg::OP_PRUNE: begin
               if (prune_en_ff && chk_valid
                   && (rd_time ^ kta_pkg::SIGN_BIT) < limit_ff) begin
                  valid_in[chk_idx] = 1'b0;
                  if (count_ff != kta_pkg::COUNT_SAT) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            kta_pkg::OP_SNAPSHOT: begin
               if (chk_valid && count_ff < lim_ff) begin
                  count_in      = count_ff + 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_count_in  = count_ff + 1'b1;
                  rsp_ev_in     = 1'b1;
                  rsp_key_in    = key_ext[DW-1:0];
                  rsp_pay_in    = rd_pay;
                  rsp_time_in   = rd_time;
                  rsp_last_in   = (count_ff + 1'b1 == lim_ff) || !more_after;
                  stop          = rsp_last_in;
               end
            end
            default: begin
               stop = 1'b0;
            end
         endcase
      end

      if (ctl.finish) begin
         rsp_strobe_in = 1'b1;
         rsp_last_in   = 1'b1;
         case (op_ff)
            kta_pkg::OP_UPSERT, kta_pkg::OP_REMOVE: begin
               if (done_ok) begin
                  rsp_slot_in       = slot_ext[SW-1:0];
                  valid_in[done_idx] = (op_ff == kta_pkg::OP_UPSERT);
               end else begin
                  rsp_status_in = kta_pkg::STATUS_FAIL;
               end
            end
            kta_pkg::OP_PRUNE: begin
               rsp_count_in = count_ff;
            end
            kta_pkg::OP_SNAPSHOT: begin
               // only reached when nothing was emitted
               rsp_count_in = '0;
            end
            default: begin
               rsp_status_in = kta_pkg::STATUS_FAIL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         count_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         count_ff       <= count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_entry_valid   = rsp_ev_ff;
   assign rsp_entry_key     = rsp_key_ff;
   assign rsp_entry_payload = rsp_pay_ff;
   assign rsp_entry_time    = $signed(rsp_time_ff);
   assign rsp_last          = rsp_last_ff;

endmodule

// File: dv/keyed_table_with_aging_tb.sv
// Self-checking testbench for the keyed table with aging: directed table, then random traffic.
`timescale 1ns / 100ps

module keyed_table_with_aging_tb;
   import kta_pkg::*;

   localparam int CAPACITY = DEF_CAPACITY;
   localparam int KEY_BITS = DEF_KEY_BITS;
   localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (DATA_W - KEY_BITS);
   localparam logic signed [DATA_W-1:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [DATA_W-1:0] T_MIN = 64'sh8000_0000_0000_0000;
   localparam int RANDOM_ITEMS = 330;
   localparam int QUIET_TAIL = 60;

   typedef struct packed {
      op_type                    op;
      logic [DATA_W-1:0]         key;
      logic [DATA_W-1:0]         payload;
      logic signed [DATA_W-1:0]  stamp;
      logic signed [DATA_W-1:0]  ttl;
      logic [COUNT_W-1:0]        max_out;
   } peer_req_type;

   typedef struct packed {
      logic                      status;
      logic [SLOT_W-1:0]         slot;
      logic [COUNT_W-1:0]        count;
      logic                      entry_valid;
      logic [DATA_W-1:0]         entry_key;
      logic [DATA_W-1:0]         entry_payload;
      logic signed [DATA_W-1:0]  entry_time;
      logic                      last;
   } peer_rsp_type;

   typedef struct packed {
      peer_req_type  req;
      bit            typed;
      peer_rsp_type  rsp;
   } peer_row_type;

   // DUT ports
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [1:0]                  req_operation = OP_UPSERT;
   logic [DATA_W-1:0]           req_key = '0;
   logic [DATA_W-1:0]           req_payload = '0;
   logic signed [DATA_W-1:0]    req_timestamp = '0;
   logic signed [DATA_W-1:0]    req_ttl = '0;
   logic [COUNT_W-1:0]          req_max_out = '0;
   logic                        rsp_strobe;
   logic                        rsp_status;
   logic [SLOT_W-1:0]           rsp_slot;
   logic [COUNT_W-1:0]          rsp_count;
   logic                        rsp_entry_valid;
   logic [DATA_W-1:0]           rsp_entry_key;
   logic [DATA_W-1:0]           rsp_entry_payload;
   logic signed [DATA_W-1:0]    rsp_entry_time;
   logic                        rsp_last;

   // Predicted peer table
   bit                          peer_live [CAPACITY];
   logic [DATA_W-1:0]           peer_key  [CAPACITY];
   logic [DATA_W-1:0]           peer_data [CAPACITY];
   logic signed [DATA_W-1:0]    peer_seen [CAPACITY];

   peer_rsp_type                op_results[$];
   peer_rsp_type                expected_rsps[$];
   peer_row_type                directed_rows[$];
   logic signed [DATA_W-1:0]    now_us = -64'sd200000;
   int                          mismatches = 0;
   int                          gap_mode = 0;

   keyed_table_with_aging dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the predicted table; results land in op_results
   function automatic void apply_peer_op(input peer_req_type rq);
      peer_rsp_type          r;
      logic [DATA_W-1:0]     k;
      logic signed [DATA_W:0] cutoff;
      int                    hit;
      int                    pruned;
      int                    emitted;
      int                    lim;
      op_results.delete();
      r = '0;
      r.last = 1'b1;
      k = rq.key & KEY_MASK;
      case (rq.op)
         OP_UPSERT, OP_REMOVE: begin
            hit = -1;
            if (k != '0) begin
               for (int i = 0; i < CAPACITY; i++)
                  if (hit < 0 && peer_live[i] && peer_key[i] == k) hit = i;
               if (rq.op == OP_UPSERT) begin
                  // no match: take the lowest free slot
                  for (int i = 0; i < CAPACITY; i++)
                     if (hit < 0 && !peer_live[i]) hit = i;
                  if (hit >= 0) begin
                     peer_live[hit] = 1'b1;
                     peer_key[hit]  = k;
                     peer_data[hit] = rq.payload;
                     peer_seen[hit] = rq.stamp;
                  end
               end else if (hit >= 0) begin
                  peer_live[hit] = 1'b0;
               end
            end
            if (hit < 0) r.status = STATUS_FAIL;
            else r.slot = hit[SLOT_W-1:0];
            op_results.push_back(r);
         end
         OP_PRUNE: begin
            pruned = 0;
            // negative ttl prunes nothing; the cutoff is exact in 65 bits
            if (!rq.ttl[DATA_W-1]) begin
               cutoff = $signed({rq.stamp[DATA_W-1], rq.stamp}) -
                        $signed({rq.ttl[DATA_W-1], rq.ttl});
               for (int i = 0; i < CAPACITY; i++) begin
                  if (peer_live[i] &&
                      $signed({peer_seen[i][DATA_W-1], peer_seen[i]}) < cutoff) begin
                     peer_live[i] = 1'b0;
                     pruned++;
                  end
               end
            end
            r.count = (pruned > 31) ? COUNT_SAT : pruned[COUNT_W-1:0];
            op_results.push_back(r);
         end
         default: begin
            emitted = 0;
            lim = (rq.max_out > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(rq.max_out);
            for (int i = 0; i < CAPACITY && emitted < lim; i++) begin
               if (peer_live[i]) begin
                  emitted++;
                  r.count         = emitted[COUNT_W-1:0];
                  r.entry_valid   = 1'b1;
                  r.entry_key     = peer_key[i];
                  r.entry_payload = peer_data[i];
                  r.entry_time    = peer_seen[i];
                  r.last          = 1'b0;
                  op_results.push_back(r);
               end
            end
            if (emitted == 0) op_results.push_back(r);
            else op_results[op_results.size()-1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic peer_req_type mk_req(op_type op, logic [DATA_W-1:0] key,
                                           logic [DATA_W-1:0] payload,
                                           logic signed [DATA_W-1:0] stamp,
                                           logic signed [DATA_W-1:0] ttl,
                                           logic [COUNT_W-1:0] max_out);
      peer_req_type rq;
      rq.op = op;
      rq.key = key;
      rq.payload = payload;
      rq.stamp = stamp;
      rq.ttl = ttl;
      rq.max_out = max_out;
      return rq;
   endfunction

   // Single-result response with no entry attached
   function automatic peer_rsp_type mk_rsp(logic status, logic [SLOT_W-1:0] slot,
                                           logic [COUNT_W-1:0] count);
      peer_rsp_type r;
      r = '0;
      r.status = status;
      r.slot = slot;
      r.count = count;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void add_row(peer_req_type rq, bit typed, peer_rsp_type rsp);
      peer_row_type row;
      row.req = rq;
      row.typed = typed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endfunction

   // Random transaction: small key pool so lookups hit, a clock that crosses zero
   function automatic peer_req_type random_request();
      peer_req_type rq;
      int roll;
      roll = $urandom_range(0, 99);
      rq.op = roll < 40 ? OP_UPSERT : roll < 60 ? OP_REMOVE :
              roll < 75 ? OP_PRUNE : OP_SNAPSHOT;
      roll = $urandom_range(0, 99);
      if (roll < 3) rq.key = '0;
      else if (roll < 8) rq.key = {$urandom, $urandom};
      else if (roll < 10) rq.key = '1;
      else rq.key = 64'($urandom_range(1, 24));
      rq.payload = {$urandom, $urandom};
      now_us += 64'($urandom_range(0, 2000));
      roll = $urandom_range(0, 99);
      if (roll < 6) rq.stamp = {$urandom, $urandom};
      else rq.stamp = now_us;
      roll = $urandom_range(0, 99);
      if (roll < 8) rq.ttl = {1'b1, 31'($urandom), $urandom};
      else if (roll < 12) rq.ttl = {$urandom, $urandom};
      else if (roll < 14) rq.ttl = T_MAX;
      else rq.ttl = 64'($urandom_range(0, 20000));
      rq.max_out = 5'($urandom_range(0, 31));
      return rq;
   endfunction

   // Present one transaction and hold it until the block takes it
   task automatic send_request(peer_req_type rq, bit typed, peer_rsp_type typed_rsp);
      start         <= 1'b1;
      req_operation <= rq.op;
      req_key       <= rq.key;
      req_payload   <= rq.payload;
      req_timestamp <= rq.stamp;
      req_ttl       <= rq.ttl;
      req_max_out   <= rq.max_out;
      do @(posedge clock); while (busy);
      apply_peer_op(rq);
      if (typed) expected_rsps.push_back(typed_rsp);
      else foreach (op_results[i]) expected_rsps.push_back(op_results[i]);
   endtask

   task automatic idle_for(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every outstanding response has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         mismatches++;
      end
   endfunction

   // Response checker
   always @(posedge clock) begin
      peer_rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_rsps.size() == 0) begin
            $error("response with no transaction pending: key %h", rsp_entry_key);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            compare_field("status", 64'(want.status), 64'(rsp_status));
            compare_field("slot", 64'(want.slot), 64'(rsp_slot));
            compare_field("count", 64'(want.count), 64'(rsp_count));
            compare_field("entry_valid", 64'(want.entry_valid), 64'(rsp_entry_valid));
            compare_field("entry_key", want.entry_key, rsp_entry_key);
            compare_field("entry_payload", want.entry_payload, rsp_entry_payload);
            compare_field("entry_time", want.entry_time, rsp_entry_time);
            compare_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   // Stimulus
   initial begin
      // empty table, bad keys, misses
      add_row(mk_req(OP_SNAPSHOT, 64'h0, 64'h0, 64'sd0, 64'sd0, 5'd16), 1,
              mk_rsp(STATUS_OK, '0, '0));
      add_row(mk_req(OP_UPSERT, 64'h0, 64'h1234, 64'sd5, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_FAIL, '0, '0));
      add_row(mk_req(OP_REMOVE, 64'h0, 64'h0, 64'sd0, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_FAIL, '0, '0));
      add_row(mk_req(OP_REMOVE, 64'h5, 64'h0, 64'sd0, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_FAIL, '0, '0));
      add_row(mk_req(OP_PRUNE, 64'h0, 64'h0, 64'sd0, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_OK, '0, '0));
      // extreme keys, payloads and times; overwrite of a live key
      add_row(mk_req(OP_UPSERT, '1, '1, T_MAX, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_OK, 4'd0, '0));
      add_row(mk_req(OP_UPSERT, 64'h1, 64'h0, T_MIN, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_OK, 4'd1, '0));
      add_row(mk_req(OP_UPSERT, '1, 64'h5555_5555_5555_5555, 64'sd0, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_OK, 4'd0, '0));
      add_row(mk_req(OP_SNAPSHOT, 64'h0, 64'h0, 64'sd0, 64'sd0, 5'd31), 0, '0);
      // negative ttl, and a cutoff that falls below the most negative time
      add_row(mk_req(OP_PRUNE, 64'h0, 64'h0, T_MAX, -64'sd1, 5'd0), 1,
              mk_rsp(STATUS_OK, '0, '0));
      add_row(mk_req(OP_PRUNE, 64'h0, 64'h0, T_MIN, T_MAX, 5'd0), 1,
              mk_rsp(STATUS_OK, '0, '0));
      // fill the rest of the table, then overflow it
      for (int i = 2; i < CAPACITY; i++)
         add_row(mk_req(OP_UPSERT, 64'h100 + 64'(i), {32'hC0DE_0000 + i, $urandom},
                        64'sd1000 * i, 64'sd0, 5'd0), 0, '0);
      add_row(mk_req(OP_UPSERT, 64'hDEAD, 64'h0, 64'sd0, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_FAIL, '0, '0));
      add_row(mk_req(OP_REMOVE, 64'h1, 64'h0, 64'sd0, 64'sd0, 5'd0), 1,
              mk_rsp(STATUS_OK, 4'd1, '0));
      add_row(mk_req(OP_SNAPSHOT, 64'h0, 64'h0, 64'sd0, 64'sd0, 5'd16), 0, '0);
      add_row(mk_req(OP_PRUNE, 64'h0, 64'h0, T_MAX, 64'sd0, 5'd0), 0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      drain();

      // random traffic; idling pattern changes every 32 transactions
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 32 == 0) gap_mode = $urandom_range(0, 2);
         if (n == RANDOM_ITEMS / 2) drain();
         if (n < RANDOM_ITEMS - QUIET_TAIL && gap_mode != 0 &&
             $urandom_range(0, 99) < (gap_mode == 1 ? 20 : 60))
            idle_for($urandom_range(1, 16));
         send_request(random_request(), 1'b0, '0);
      end
      start <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
